[src/i2m_pkg.sv]
// ----------------------------------------------------------------------------
// IP-to-MAC table package
// Shared types, codes and defaults of the IPv4-to-MAC address table.
// ----------------------------------------------------------------------------
package i2m_pkg;

  // Default number of table entries, one per cell.
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam int unsigned IP_W      = 32;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_RAW_W  = CMD_W + IP_W + MAC_W;
  localparam int unsigned IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W  = 1 + MAC_W + STATUS_W;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2
  } i2m_cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } i2m_status_e;

  // One table entry as it moves between cells.
  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } i2m_entry_t;

  // Search result carried along the chain toward cell 0.
  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
  } i2m_carry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic shift;    // insert: every cell takes its newer neighbor's entry
    logic capture;  // compare the key and latch the match flag
    logic purge;    // drop matching entries while capturing
    logic scan;     // move the search result one cell toward the front
    logic compact;  // odd-even exchange step closing holes
    logic phase;    // parity of the exchange step
  } i2m_ctrl_t;

endpackage

[src/ip_to_mac_table_core.sv]
// ----------------------------------------------------------------------------
// IP-to-MAC table core
// Bounded IPv4-to-MAC table built as a chain of cells, newest entry first.
// ----------------------------------------------------------------------------
// Each request is one command and yields one result. An insert (or an
// unknown command) is answered from the result register in the cycle
// after it is accepted; an insert into a table with room shifts all cells
// by one place toward the old end and cell 0 takes the new pair. A lookup
// or a delete compares the key in every cell at once, then moves the
// newest match down the chain to cell 0 before the result is registered.
// A delete closes the holes it leaves with odd-even exchanges between
// neighboring cells during the same pass. One command is worked on at a
// time; the result register lets the next request in while it drains.
// Reset empties the table; no clearing pass is needed.
module ip_to_mac_table_core #(
  parameter int unsigned TABLE_ENTRIES = i2m_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // command [1:0], ip_address [33:2], mac_address [81:34], zero padding
  input  logic [i2m_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // hit [0], mac_result [48:1], status [50:49], zero padding
  output logic [i2m_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } i2m_state_e;

  i2m_state_e                    state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          del_q, del_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_hit_q, out_hit_d;
  logic [i2m_pkg::MAC_W-1:0]     out_mac_q, out_mac_d;
  i2m_pkg::i2m_status_e          out_status_q, out_status_d;

  logic                          accept;
  logic                          out_free;
  logic                          full;
  i2m_pkg::i2m_cmd_e             cmd;
  logic [i2m_pkg::IP_W-1:0]      in_ip;
  logic [i2m_pkg::MAC_W-1:0]     in_mac;
  i2m_pkg::i2m_ctrl_t            ctrl;
  i2m_pkg::i2m_entry_t           new_entry;
  i2m_pkg::i2m_entry_t           entry_w [TABLE_ENTRIES];
  i2m_pkg::i2m_carry_t           carry_w [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]      valid_vec;

  // Unpack the request.
  assign cmd    = i2m_pkg::i2m_cmd_e'(s_axis_tdata_i[1:0]);
  assign in_ip  = s_axis_tdata_i[33:2];
  assign in_mac = s_axis_tdata_i[81:34];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = entry_w[TABLE_ENTRIES-1].valid;

  assign new_entry.valid = 1'b1;
  assign new_entry.ip    = in_ip;
  assign new_entry.mac   = in_mac;

  // Control broadcast to the cells.
  always_comb begin
    ctrl.shift   = accept && (cmd == i2m_pkg::CMD_INSERT) && !full;
    ctrl.capture = accept && ((cmd == i2m_pkg::CMD_LOOKUP) ||
                              (cmd == i2m_pkg::CMD_DELETE));
    ctrl.purge   = (cmd == i2m_pkg::CMD_DELETE);
    ctrl.scan    = (state_q == S_SCAN);
    ctrl.compact = (state_q == S_SCAN) && del_q;
    ctrl.phase   = cnt_q[0];
  end

  // The chain of cells, cell 0 holding the newest entry.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    i2m_pkg::i2m_entry_t prev_w;
    i2m_pkg::i2m_entry_t next_w;
    i2m_pkg::i2m_carry_t next_carry_w;

    if (i == 0) begin : g_first
      assign prev_w = new_entry;
    end else begin : g_prev
      assign prev_w = entry_w[i-1];
    end

    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign next_w       = '0;
      assign next_carry_w = '0;
    end else begin : g_next
      assign next_w       = entry_w[i+1];
      assign next_carry_w = carry_w[i+1];
    end

    i2m_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (in_ip),
      .prev_i       (prev_w),
      .next_i       (next_w),
      .next_carry_i (next_carry_w),
      .entry_o      (entry_w[i]),
      .carry_o      (carry_w[i])
    );

    assign valid_vec[i] = entry_w[i].valid;
  end

  // Sequencer and result register.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    del_d        = del_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_hit_d    = out_hit_q;
    out_mac_d    = out_mac_q;
    out_status_d = out_status_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd) inside
            i2m_pkg::CMD_LOOKUP, i2m_pkg::CMD_DELETE: begin
              state_d = S_SCAN;
              cnt_d   = '0;
              del_d   = (cmd == i2m_pkg::CMD_DELETE);
            end
            i2m_pkg::CMD_INSERT: begin
              out_valid_d  = 1'b1;
              out_hit_d    = 1'b0;
              out_mac_d    = '0;
              out_status_d = full ? i2m_pkg::ST_FULL : i2m_pkg::ST_DONE;
            end
            default: begin
              out_valid_d  = 1'b1;
              out_hit_d    = 1'b0;
              out_mac_d    = '0;
              out_status_d = i2m_pkg::ST_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d      = S_IDLE;
          out_valid_d  = 1'b1;
          out_hit_d    = carry_w[0].hit;
          out_mac_d    = (carry_w[0].hit && !del_q) ? carry_w[0].mac : '0;
          out_status_d = carry_w[0].hit ? i2m_pkg::ST_DONE : i2m_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      del_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      del_q       <= del_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q    <= out_hit_d;
    out_mac_q    <= out_mac_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(i2m_pkg::OUT_DATA_W - i2m_pkg::OUT_RAW_W){1'b0}},
                            out_status_q, out_mac_q, out_hit_q};

`ifndef ASSERT_OFF
  // Between commands the valid entries fill the front of the chain.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> $onehot({1'b0, valid_vec} + 1'b1))
    else $error("table entries are not contiguous");

  // An insert into a table with room lands in cell 0.
  a_insert_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == i2m_pkg::CMD_INSERT) && !full) |=> valid_vec[0])
    else $error("inserted entry missing from cell 0");

  // A reported hit always comes with a done status.
  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hit_q) |-> (out_status_q == i2m_pkg::ST_DONE))
    else $error("hit reported with a failure status");
`endif

endmodule

[src/i2m_cell.sv]
// ----------------------------------------------------------------------------
// IP-to-MAC table cell
// Holds one entry, compares it to the key and passes data to its neighbors.
// ----------------------------------------------------------------------------
module i2m_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  i2m_pkg::i2m_ctrl_t            ctrl_i,
  input  logic [i2m_pkg::IP_W-1:0]      key_i,
  input  i2m_pkg::i2m_entry_t           prev_i,       // newer neighbor
  input  i2m_pkg::i2m_entry_t           next_i,       // older neighbor
  input  i2m_pkg::i2m_carry_t           next_carry_i,
  output i2m_pkg::i2m_entry_t           entry_o,
  output i2m_pkg::i2m_carry_t           carry_o
);

  // A cell with even parity is the left side of a pair on even steps.
  localparam logic PARITY = ((INDEX % 2) == 1) ? 1'b1 : 1'b0;

  logic                        valid_q, valid_d;
  logic [i2m_pkg::IP_W-1:0]    ip_q, ip_d;
  logic [i2m_pkg::MAC_W-1:0]   mac_q, mac_d;
  logic                        flag_q, flag_d;
  i2m_pkg::i2m_carry_t         carry_q, carry_d;
  logic                        match;

  assign match = valid_q && (ip_q == key_i);

  // Next-state logic for the entry, the match flag and the search carry.
  always_comb begin
    valid_d = valid_q;
    ip_d    = ip_q;
    mac_d   = mac_q;
    flag_d  = flag_q;
    carry_d = carry_q;
    if (ctrl_i.shift) begin
      valid_d = prev_i.valid;
      ip_d    = prev_i.ip;
      mac_d   = prev_i.mac;
    end
    if (ctrl_i.capture) begin
      flag_d  = match;
      carry_d = '0;
      if (ctrl_i.purge && match) begin
        valid_d = 1'b0;
      end
    end
    if (ctrl_i.scan) begin
      if (flag_q) begin
        carry_d.hit = 1'b1;
        carry_d.mac = mac_q;
      end else begin
        carry_d = next_carry_i;
      end
      // Exchange a hole with the valid entry behind it, keeping age order.
      if (ctrl_i.compact) begin
        if (PARITY == ctrl_i.phase) begin
          if (!valid_q && next_i.valid) begin
            valid_d = next_i.valid;
            ip_d    = next_i.ip;
            mac_d   = next_i.mac;
          end
        end else begin
          if (!prev_i.valid && valid_q) begin
            valid_d = 1'b0;
            ip_d    = prev_i.ip;
            mac_d   = prev_i.mac;
          end
        end
      end
    end
  end

  // Control state and search carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= 1'b0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      flag_q  <= flag_d;
      carry_q <= carry_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    ip_q  <= ip_d;
    mac_q <= mac_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.ip    = ip_q;
  assign entry_o.mac   = mac_q;
  assign carry_o       = carry_q;

endmodule
